// ===== design/swlpe_pkg.sv =====
// shared types, codes and reset values for the single-wire led pulse encoder
// no dependencies; used by every module of the block
package swlpe_pkg;

   localparam int unsigned TICK_W  = 16;
   localparam int unsigned CSR_IDX_W = 3;

   typedef logic [TICK_W-1:0] tick_type;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_BYTE  = 2'd1,
      KIND_LATCH = 2'd2
   } kind_type;

   localparam logic [CSR_IDX_W-1:0] CSR_ONE_HIGH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_LOW   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_LOW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LATCH     = 3'd4;

   localparam tick_type RST_ONE_HIGH  = 16'd43;
   localparam tick_type RST_ONE_LOW   = 16'd13;
   localparam tick_type RST_ZERO_HIGH = 16'd20;
   localparam tick_type RST_ZERO_LOW  = 16'd30;
   localparam tick_type RST_LATCH     = 16'd3000;

   typedef struct packed {
      tick_type one_high;
      tick_type one_low;
      tick_type zero_high;
      tick_type zero_low;
      tick_type latch;
   } cfg_type;

   typedef struct packed {
      logic right_level;
      logic left_level;
      logic busy_res;
      logic accepted;
   } rsp_type;

endpackage

// ===== design/swlpe_csr.sv =====
// timing configuration registers, written through the plain csr write port
// depends on swlpe_pkg
module swlpe_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [swlpe_pkg::CSR_IDX_W-1:0] csr_index,
   input  swlpe_pkg::tick_type             csr_wr_data,
   output swlpe_pkg::cfg_type              cfg
);

   swlpe_pkg::cfg_type cfg_ff;
   swlpe_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            swlpe_pkg::CSR_ONE_HIGH:  cfg_in.one_high  = csr_wr_data;
            swlpe_pkg::CSR_ONE_LOW:   cfg_in.one_low   = csr_wr_data;
            swlpe_pkg::CSR_ZERO_HIGH: cfg_in.zero_high = csr_wr_data;
            swlpe_pkg::CSR_ZERO_LOW:  cfg_in.zero_low  = csr_wr_data;
            swlpe_pkg::CSR_LATCH:     cfg_in.latch     = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.one_high  <= swlpe_pkg::RST_ONE_HIGH;
         cfg_ff.one_low   <= swlpe_pkg::RST_ONE_LOW;
         cfg_ff.zero_high <= swlpe_pkg::RST_ZERO_HIGH;
         cfg_ff.zero_low  <= swlpe_pkg::RST_ZERO_LOW;
         cfg_ff.latch     <= swlpe_pkg::RST_LATCH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/swlpe_core.sv =====
// bit sequencer: shift byte, bit index, phase timer and line levels, one step per request
// depends on swlpe_pkg
module swlpe_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [1:0]          kind,
   input  logic [7:0]          data_byte,
   input  logic                line_select,
   input  logic                end_of_frame,
   input  swlpe_pkg::cfg_type  cfg,
   output swlpe_pkg::rsp_type  result
);

   logic [7:0]          shift_ff, shift_in;
   logic [2:0]          index_ff, index_in;
   logic                high_ff, high_in;
   swlpe_pkg::tick_type timer_ff, timer_in;
   logic                active_ff, active_in;
   logic                in_latch_ff, in_latch_in;
   logic                pending_ff, pending_in;
   logic                line_ff, line_in;
   logic [1:0]          levels_ff, levels_in;
   logic                taken;
   logic                cur_bit;
   logic                nxt_bit;
   logic [2:0]          index_inc;

   assign index_inc = index_ff + 3'd1;
   assign cur_bit   = shift_ff[index_ff];
   assign nxt_bit   = shift_ff[index_inc];

   always_comb begin
      shift_in    = shift_ff;
      index_in    = index_ff;
      high_in     = high_ff;
      timer_in    = timer_ff;
      active_in   = active_ff;
      in_latch_in = in_latch_ff;
      pending_in  = pending_ff;
      line_in     = line_ff;
      levels_in   = levels_ff;
      taken       = 1'b0;
      if (step) begin
         case (swlpe_pkg::kind_type'(kind))
            swlpe_pkg::KIND_TICK: begin
               if (active_ff) begin
                  if (timer_ff > 16'd1) begin
                     timer_in = timer_ff - 16'd1;
                  end else if (in_latch_ff) begin
                     in_latch_in = 1'b0;
                     active_in   = 1'b0;
                     timer_in    = '0;
                     levels_in   = 2'b00;
                  end else if (high_ff) begin
                     high_in   = 1'b0;
                     timer_in  = cur_bit ? cfg.one_low : cfg.zero_low;
                     levels_in = 2'b00;
                  end else if (index_ff == 3'd7) begin
                     if (pending_ff) begin
                        in_latch_in = 1'b1;
                        pending_in  = 1'b0;
                        high_in     = 1'b0;
                        active_in   = 1'b1;
                        timer_in    = cfg.latch;
                        levels_in   = 2'b00;
                     end else begin
                        active_in = 1'b0;
                        timer_in  = '0;
                        levels_in = 2'b00;
                     end
                  end else begin
                     index_in  = index_inc;
                     high_in   = 1'b1;
                     timer_in  = nxt_bit ? cfg.one_high : cfg.zero_high;
                     levels_in = line_ff ? 2'b10 : 2'b01;
                  end
               end
            end
            swlpe_pkg::KIND_BYTE: begin
               if (!active_ff) begin
                  shift_in    = data_byte;
                  line_in     = line_select;
                  pending_in  = end_of_frame;
                  index_in    = 3'd0;
                  in_latch_in = 1'b0;
                  active_in   = 1'b1;
                  high_in     = 1'b1;
                  timer_in    = data_byte[0] ? cfg.one_high : cfg.zero_high;
                  levels_in   = line_select ? 2'b10 : 2'b01;
                  taken       = 1'b1;
               end
            end
            swlpe_pkg::KIND_LATCH: begin
               if (!active_ff) begin
                  in_latch_in = 1'b1;
                  pending_in  = 1'b0;
                  high_in     = 1'b0;
                  active_in   = 1'b1;
                  timer_in    = cfg.latch;
                  levels_in   = 2'b00;
                  taken       = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff    <= '0;
         index_ff    <= '0;
         high_ff     <= 1'b0;
         timer_ff    <= '0;
         active_ff   <= 1'b0;
         in_latch_ff <= 1'b0;
         pending_ff  <= 1'b0;
         line_ff     <= 1'b0;
         levels_ff   <= 2'b00;
      end else begin
         shift_ff    <= shift_in;
         index_ff    <= index_in;
         high_ff     <= high_in;
         timer_ff    <= timer_in;
         active_ff   <= active_in;
         in_latch_ff <= in_latch_in;
         pending_ff  <= pending_in;
         line_ff     <= line_in;
         levels_ff   <= levels_in;
      end
   end

   assign result.right_level = levels_in[0];
   assign result.left_level  = levels_in[1];
   assign result.busy_res    = active_in;
   assign result.accepted    = taken;

endmodule

// ===== design/swlpe_rsp_buf.sv =====
// two-entry response buffer: output register plus skid register
// depends on swlpe_pkg
module swlpe_rsp_buf (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  swlpe_pkg::rsp_type push_data,
   output logic               room,
   output logic               out_valid,
   input  logic               out_ready,
   output swlpe_pkg::rsp_type out_data
);

   logic               main_valid_ff, main_valid_in;
   logic               skid_valid_ff, skid_valid_in;
   swlpe_pkg::rsp_type main_ff, main_in;
   swlpe_pkg::rsp_type skid_ff, skid_in;
   logic               pop;

   assign pop  = main_valid_ff & out_ready;
   assign room = !skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

// ===== design/single_wire_led_pulse_encoder.sv =====
// top level of the two-line single-wire led pulse encoder
// depends on swlpe_pkg, swlpe_csr, swlpe_core and swlpe_rsp_buf
//
// A request is taken when req_valid and req_ready are high and gives exactly one response,
// registered and shown on rsp_valid the cycle after acceptance unless an older one still waits.
// Tick requests stand for time: each advances the current high, low or latch phase by one count.
// One request is taken per cycle while req_ready is high; a two-entry response buffer holds up
// to two responses while rsp_ready is low, and req_ready drops only when both are full. The user
// must write timing registers via the csr port only while no request is outstanding; unenforced.
module single_wire_led_pulse_encoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_kind,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_line_select,
   input  logic                            req_end_of_frame,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_right_level,
   output logic                            rsp_left_level,
   output logic                            rsp_busy_res,
   output logic                            rsp_accepted,
   input  logic                            csr_wr_en,
   input  logic [swlpe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                     csr_wr_data
);

   swlpe_pkg::cfg_type cfg;
   swlpe_pkg::rsp_type step_rsp;
   swlpe_pkg::rsp_type out_rsp;
   logic               req_fire;

   assign req_fire = req_valid & req_ready;

   swlpe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   swlpe_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (req_fire),
      .kind         (req_kind),
      .data_byte    (req_data_byte),
      .line_select  (req_line_select),
      .end_of_frame (req_end_of_frame),
      .cfg          (cfg),
      .result       (step_rsp)
   );

   swlpe_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_fire),
      .push_data (step_rsp),
      .room      (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_rsp)
   );

   assign rsp_right_level = out_rsp.right_level;
   assign rsp_left_level  = out_rsp.left_level;
   assign rsp_busy_res    = out_rsp.busy_res;
   assign rsp_accepted    = out_rsp.accepted;

`ifndef SYNTHESIS
   a_full_implies_valid: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request side stalled with no response pending");

   a_accept_implies_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepted) |-> rsp_busy_res)
      else $error("accepted request without busy");

   a_one_line_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_right_level && rsp_left_level))
      else $error("both data lines high");

   a_high_implies_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_right_level || rsp_left_level)) |-> rsp_busy_res)
      else $error("data line high while idle");
`endif

endmodule
